### rtl/core/spg_pkg.sv
// shared types, constants and helpers for the sigma point generator
// no dependencies
package spg_pkg;

    localparam int MAX_DIM = 5;
    localparam int FAC_DEPTH = MAX_DIM * MAX_DIM;
    localparam int FAC_AW = $clog2(FAC_DEPTH);
    localparam int MEAN_AW = $clog2(MAX_DIM);

    localparam int ACC_W = 50;
    localparam int RAD_W = 48;
    localparam int ROOT_W = 24;
    localparam int NUM_W = 63;

    typedef enum logic [1:0] {
        ACT_LOAD_MEAN = 2'd0,
        ACT_LOAD_COV  = 2'd1,
        ACT_GENERATE  = 2'd2,
        ACT_UNUSED    = 2'd3
    } action_t;

    typedef enum logic {
        REG_DIM    = 1'b0,
        REG_SPREAD = 1'b1
    } reg_index_t;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_NOT_PD = 1'b1;

    // flat address of a factor entry
    function automatic logic [FAC_AW-1:0] fac_addr(input logic [2:0] row,
                                                   input logic [2:0] col);
        logic [7:0] a;
        begin
            a = 8'(row) * 8'(MAX_DIM) + 8'(col);
            return a[FAC_AW-1:0];
        end
    endfunction

    // saturate a 48-bit signed value to 32 bits
    function automatic logic signed [31:0] sat48(input logic signed [47:0] x);
        begin
            if (x > 48'sh0000_7FFF_FFFF)
                return 32'sh7FFF_FFFF;
            else if (x < -48'sh0000_8000_0000)
                return -32'sh8000_0000;
            else
                return x[31:0];
        end
    endfunction

endpackage

### rtl/core/spg_if.sv
// channel interfaces for the sigma point generator: input, result and register write
// depends on spg_pkg
interface spg_in_if;
    import spg_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [2:0]        row_index;
    logic [2:0]        col_index;
    logic signed [31:0] value;
    modport source (output valid, action, row_index, col_index, value, input ready);
    modport sink (input valid, action, row_index, col_index, value, output ready);
endinterface

interface spg_out_if;
    logic              valid;
    logic              ready;
    logic [3:0]        point_index;
    logic [2:0]        element_index;
    logic signed [31:0] point_value;
    logic              status;
    logic              last;
    modport source (output valid, point_index, element_index, point_value, status, last,
                    input ready);
    modport sink (input valid, point_index, element_index, point_value, status, last,
                  output ready);
endinterface

interface spg_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [30:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/spg_sqrt.sv
// bit-serial integer square root, two radicand bits per cycle
// depends on spg_pkg
module spg_sqrt
    import spg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [RAD_W-1:0]  x_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W+2:0] rem_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;

    assign rem_sh = {rem_reg[ROOT_W:0], x_reg[RAD_W-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= {x_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### rtl/core/spg_div.sv
// restoring divider, one quotient bit per cycle, signed result saturated to 32 bits
// depends on spg_pkg
module spg_div
    import spg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NUM_W-1:0]   dividend,
    input  logic               negative,
    input  logic [ROOT_W-1:0]  divisor,
    output logic               done,
    output logic signed [31:0] quotient
);

    logic [NUM_W-1:0]  n_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [ROOT_W:0]   rem_reg;
    logic [ROOT_W-1:0] d_reg;
    logic              neg_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [ROOT_W:0]   rem_sh;

    assign rem_sh = {rem_reg[ROOT_W-1:0], n_reg[NUM_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= dividend;
            q_reg   <= '0;
            rem_reg <= '0;
            d_reg   <= divisor;
            neg_reg <= negative;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[NUM_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, d_reg})
            begin
                rem_reg <= rem_sh - {1'b0, d_reg};
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    // truncation toward zero: magnitude divided, sign applied after
    always_comb
    begin
        if (neg_reg)
        begin
            if (q_reg > 63'h8000_0000)
                quotient = -32'sh8000_0000;
            else
                quotient = 32'(-q_reg[31:0]);
        end
        else
        begin
            if (q_reg > 63'h7FFF_FFFF)
                quotient = 32'sh7FFF_FFFF;
            else
                quotient = q_reg[31:0];
        end
    end

    assign done = done_reg;

endmodule

### rtl/core/sigma_point_generator.sv
// sigma point generator: loads are taken while idle; generate scales, factors and
// emits 2n+1 points, one result at a time. factoring is bound by the single read
// port of the factor memory (two reads, multiply, subtract per product term), a
// serial square root per pivot and a serial division per off-diagonal entry.
// reset clears control and registers (n = 1, spread 1.0); stores are undefined
// until written and need no clearing pass
module sigma_point_generator
    import spg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    spg_in_if.sink      in_ch,
    spg_out_if.source   out_ch,
    spg_cfg_if.sink     cfg
);

    typedef enum logic [3:0] {
        S_IDLE, S_SRD, S_SMUL, S_SWB, S_ARD, S_AINIT, S_RA, S_RB, S_MUL, S_SUB,
        S_CHK, S_SQRT, S_DIV, S_ERR, S_ERD, S_EMIT
    } state_t;

    state_t state_reg;

    logic [2:0]  dim_reg;
    logic [30:0] spread_reg;
    logic [2:0]  n_reg, i_reg, j_reg, k_reg, e_reg;
    logic [3:0]  p_reg;

    logic signed [31:0]      a_reg;
    logic signed [63:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [ROOT_W-1:0]       piv_reg;

    logic               out_valid_reg;
    logic [3:0]         out_point_reg;
    logic [2:0]         out_elem_reg;
    logic signed [31:0] out_value_reg;
    logic               out_status_reg;
    logic               out_last_reg;

    logic signed [31:0] fac_mem [FAC_DEPTH];
    logic signed [31:0] mean_mem [MAX_DIM];
    logic signed [31:0] fac_rd_reg;
    logic signed [31:0] mean_rd_reg;

    // memory access controls
    logic               fac_re, fac_we, mean_we;
    logic [FAC_AW-1:0]  fac_raddr, fac_waddr;
    logic signed [31:0] fac_wdata;

    logic signed [63:0] rsum;
    logic signed [47:0] rnd;
    logic [2:0]         fr;
    logic               out_free;
    logic               in_fire;
    logic               last_elem;
    logic               more_i, more_j;

    logic signed [ACC_W-1:0] d_clamp, v_clamp, v_abs;
    logic                    sqrt_start, sqrt_done, div_start, div_done;
    logic [ROOT_W-1:0]       sqrt_root;
    logic signed [31:0]      div_q;
    logic signed [32:0]      emit_sum;
    logic signed [31:0]      emit_l;

    assign in_fire = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign out_free = !out_valid_reg || out_ch.ready;

    assign rsum = prod_reg + 64'sd32768;
    assign rnd = rsum[63:16];

    assign more_i = (i_reg + 3'd1) < n_reg;
    assign more_j = (j_reg + 3'd1) < n_reg;

    assign fr = (p_reg <= {1'b0, n_reg}) ? 3'(p_reg - 4'd1) : 3'(p_reg - 4'd1 - {1'b0, n_reg});
    assign last_elem = (p_reg == {n_reg, 1'b0}) && (e_reg == n_reg - 3'd1);

    assign emit_l = (p_reg != 4'd0 && e_reg <= fr) ? fac_rd_reg : 32'sd0;
    assign emit_sum = (p_reg <= {1'b0, n_reg}) ? 33'(mean_rd_reg) + 33'(emit_l)
                                              : 33'(mean_rd_reg) - 33'(emit_l);

    always_comb
    begin
        d_clamp = acc_reg;
        if (acc_reg > ACC_W'(32'sh7FFF_FFFF))
            d_clamp = ACC_W'(32'sh7FFF_FFFF);
        v_clamp = acc_reg;
        if (acc_reg > (ACC_W'(1) <<< 46))
            v_clamp = ACC_W'(1) <<< 46;
        else if (acc_reg < -(ACC_W'(1) <<< 46))
            v_clamp = -(ACC_W'(1) <<< 46);
        v_abs = v_clamp[ACC_W-1] ? -v_clamp : v_clamp;
    end

    assign sqrt_start = (state_reg == S_CHK) && (i_reg == j_reg) && !acc_reg[ACC_W-1]
                        && (acc_reg != '0);
    assign div_start = (state_reg == S_CHK) && (i_reg != j_reg);

    spg_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({d_clamp[31:0], 16'h0000}),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    spg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({v_abs[46:0], 16'h0000}),
        .negative (v_clamp[ACC_W-1]),
        .divisor  (piv_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        fac_re = 1'b0;
        fac_raddr = fac_addr(i_reg, j_reg);
        fac_we = 1'b0;
        fac_waddr = fac_addr(i_reg, j_reg);
        fac_wdata = in_ch.value;
        mean_we = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                fac_waddr = fac_addr(in_ch.row_index, in_ch.col_index);
                fac_we = in_fire && (in_ch.action == ACT_LOAD_COV)
                         && (in_ch.row_index < 3'(MAX_DIM)) && (in_ch.col_index < 3'(MAX_DIM));
                mean_we = in_fire && (in_ch.action == ACT_LOAD_MEAN)
                          && (in_ch.row_index < 3'(MAX_DIM));
            end
            S_SRD, S_ARD: fac_re = 1'b1;
            S_SWB:
            begin
                fac_we = 1'b1;
                fac_wdata = sat48(rnd);
            end
            S_RA:
            begin
                fac_re = 1'b1;
                fac_raddr = fac_addr(i_reg, k_reg);
            end
            S_RB:
            begin
                fac_re = 1'b1;
                fac_raddr = fac_addr(j_reg, k_reg);
            end
            S_SQRT:
            begin
                fac_we = sqrt_done;
                fac_wdata = 32'(sqrt_root);
            end
            S_DIV:
            begin
                fac_we = div_done;
                fac_wdata = div_q;
            end
            S_ERD:
            begin
                fac_re = out_free;
                fac_raddr = fac_addr(fr, e_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fac_we)
            fac_mem[fac_waddr] <= fac_wdata;
        if (fac_re)
            fac_rd_reg <= fac_mem[fac_raddr];
        if (mean_we)
            mean_mem[in_ch.row_index[MEAN_AW-1:0]] <= in_ch.value;
        if (state_reg == S_ERD && out_free)
            mean_rd_reg <= mean_mem[e_reg[MEAN_AW-1:0]];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_SMUL: prod_reg <= 64'(fac_rd_reg) * 64'($signed({1'b0, spread_reg}));
            S_RB: a_reg <= fac_rd_reg;
            S_MUL: prod_reg <= 64'(a_reg) * 64'(fac_rd_reg);
            S_AINIT: acc_reg <= ACC_W'(fac_rd_reg);
            S_SUB: acc_reg <= acc_reg - ACC_W'(rnd);
            S_SQRT: if (sqrt_done) piv_reg <= sqrt_root;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            dim_reg        <= 3'd1;
            spread_reg     <= 31'd65536;
            n_reg          <= 3'd1;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            p_reg          <= '0;
            e_reg          <= '0;
            out_valid_reg  <= 1'b0;
            out_point_reg  <= '0;
            out_elem_reg   <= '0;
            out_value_reg  <= '0;
            out_status_reg <= STATUS_OK;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            if (cfg.valid)
            begin
                unique case (reg_index_t'(cfg.index))
                    REG_DIM: dim_reg <= cfg.data[2:0];
                    REG_SPREAD: spread_reg <= cfg.data;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && in_ch.action == ACT_GENERATE)
                    begin
                        if (dim_reg == 3'd0)
                            n_reg <= 3'd1;
                        else if (dim_reg > 3'(MAX_DIM))
                            n_reg <= 3'(MAX_DIM);
                        else
                            n_reg <= dim_reg;
                        i_reg <= '0;
                        j_reg <= '0;
                        state_reg <= S_SRD;
                    end
                end
                S_SRD: state_reg <= S_SMUL;
                S_SMUL: state_reg <= S_SWB;
                S_SWB:
                begin
                    if (j_reg < i_reg)
                    begin
                        j_reg <= j_reg + 3'd1;
                        state_reg <= S_SRD;
                    end
                    else if (more_i)
                    begin
                        i_reg <= i_reg + 3'd1;
                        j_reg <= '0;
                        state_reg <= S_SRD;
                    end
                    else
                    begin
                        i_reg <= '0;
                        j_reg <= '0;
                        state_reg <= S_ARD;
                    end
                end
                S_ARD: state_reg <= S_AINIT;
                S_AINIT:
                begin
                    k_reg <= '0;
                    state_reg <= (j_reg == 3'd0) ? S_CHK : S_RA;
                end
                S_RA: state_reg <= S_RB;
                S_RB: state_reg <= S_MUL;
                S_MUL: state_reg <= S_SUB;
                S_SUB:
                begin
                    if (k_reg + 3'd1 == j_reg)
                        state_reg <= S_CHK;
                    else
                    begin
                        k_reg <= k_reg + 3'd1;
                        state_reg <= S_RA;
                    end
                end
                S_CHK:
                begin
                    if (i_reg != j_reg)
                        state_reg <= S_DIV;
                    else if (sqrt_start)
                        state_reg <= S_SQRT;
                    else
                        state_reg <= S_ERR;
                end
                S_SQRT, S_DIV:
                begin
                    if ((state_reg == S_SQRT && sqrt_done) || (state_reg == S_DIV && div_done))
                    begin
                        if (more_i)
                        begin
                            i_reg <= i_reg + 3'd1;
                            state_reg <= S_ARD;
                        end
                        else if (more_j)
                        begin
                            j_reg <= j_reg + 3'd1;
                            i_reg <= j_reg + 3'd1;
                            state_reg <= S_ARD;
                        end
                        else
                        begin
                            p_reg <= '0;
                            e_reg <= '0;
                            state_reg <= S_ERD;
                        end
                    end
                end
                S_ERR:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_point_reg  <= '0;
                        out_elem_reg   <= '0;
                        out_value_reg  <= '0;
                        out_status_reg <= STATUS_NOT_PD;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                S_ERD:
                begin
                    if (out_free)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    // slot was free at the read, so it is free now
                    out_valid_reg  <= 1'b1;
                    out_point_reg  <= p_reg;
                    out_elem_reg   <= e_reg;
                    out_value_reg  <= sat48(48'(emit_sum));
                    out_status_reg <= STATUS_OK;
                    out_last_reg   <= last_elem;
                    if (last_elem)
                        state_reg <= S_IDLE;
                    else
                    begin
                        state_reg <= S_ERD;
                        if (e_reg == n_reg - 3'd1)
                        begin
                            e_reg <= '0;
                            p_reg <= p_reg + 4'd1;
                        end
                        else
                            e_reg <= e_reg + 3'd1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.point_index = out_point_reg;
    assign out_ch.element_index = out_elem_reg;
    assign out_ch.point_value = out_value_reg;
    assign out_ch.status = out_status_reg;
    assign out_ch.last = out_last_reg;

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg |-> out_last_reg && out_value_reg == 32'sd0)
        else $error("error result malformed");

    a_pivot_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SQRT |-> !acc_reg[ACC_W-1] && acc_reg != '0)
        else $error("square root started on non-positive pivot");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> !out_valid_reg || $past(out_ch.ready))
        else $error("result register overwritten");

    a_div_piv: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> piv_reg != '0)
        else $error("division by zero pivot");

endmodule

### verif/spg_checker.sv
// checker for the sigma point generator: watches the input, result and register channels,
// predicts every result and compares it against the block's output
// depends on spg_pkg and the channel interfaces in spg_if
module spg_checker
    import spg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    spg_in_if         in_ch,
    spg_out_if        out_ch,
    spg_cfg_if        cfg,
    output int        errors,
    output int        pending,
    output int        results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [3:0]         point_index;
        logic [2:0]         element_index;
        logic signed [31:0] point_value;
        logic               status;
        logic               last;
    } point_t;

    point_t             expected_points[$];
    logic [2:0]         dim_reg;
    logic [30:0]        spread_reg;
    logic signed [31:0] mean_mem[MAX_DIM];
    logic signed [31:0] fac_mem[MAX_DIM*MAX_DIM];

    function automatic logic signed [31:0] clip32(input longint x);
        if (x > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (x < -64'sd2147483648)
            return 32'sh8000_0000;
        return x[31:0];
    endfunction

    // q16.16 product, round half up, floor shift
    function automatic longint qprod(input longint a, input longint b);
        return (a * b + 64'sd32768) >>> 16;
    endfunction

    function automatic longint root_floor(input longint x);
        logic [63:0] rem, r, bitv;
        rem = x;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= r + bitv)
            begin
                rem = rem - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return longint'(r);
    endfunction

    // scale by spread, then lower cholesky in place; 0 on a non-positive pivot
    function automatic bit cholesky_in_place(input int n);
        longint d, piv, v, l;
        for (int i = 0; i < n; i++)
            for (int j = 0; j <= i; j++)
                fac_mem[i*MAX_DIM+j] = clip32(qprod(fac_mem[i*MAX_DIM+j],
                                                    longint'(spread_reg)));
        for (int j = 0; j < n; j++)
        begin
            d = fac_mem[j*MAX_DIM+j];
            for (int k = 0; k < j; k++)
            begin
                l = fac_mem[j*MAX_DIM+k];
                d -= qprod(l, l);
            end
            if (d <= 0)
                return 1'b0;
            if (d > 64'sd2147483647)
                d = 64'sd2147483647;
            piv = root_floor(d * 65536);
            fac_mem[j*MAX_DIM+j] = clip32(piv);
            for (int i = j + 1; i < n; i++)
            begin
                v = fac_mem[i*MAX_DIM+j];
                for (int k = 0; k < j; k++)
                    v -= qprod(fac_mem[i*MAX_DIM+k], fac_mem[j*MAX_DIM+k]);
                if (v > 64'sd70368744177664)
                    v = 64'sd70368744177664;
                if (v < -64'sd70368744177664)
                    v = -64'sd70368744177664;
                fac_mem[i*MAX_DIM+j] = clip32((v * 65536) / piv);
            end
        end
        return 1'b1;
    endfunction

    task automatic predict_points();
        int n, fr, total, cnt;
        longint m, l, r;
        point_t pt;
        n = dim_reg;
        if (n < 1)
            n = 1;
        if (n > MAX_DIM)
            n = MAX_DIM;
        if (!cholesky_in_place(n))
        begin
            pt = '{4'd0, 3'd0, 32'sd0, STATUS_NOT_PD, 1'b1};
            expected_points.push_back(pt);
            return;
        end
        total = (2 * n + 1) * n;
        cnt = 0;
        for (int p = 0; p < 2 * n + 1; p++)
            for (int e = 0; e < n; e++)
            begin
                m = mean_mem[e];
                if (p == 0)
                    r = m;
                else
                begin
                    fr = (p <= n) ? p - 1 : p - 1 - n;
                    l = (e <= fr) ? longint'(fac_mem[fr*MAX_DIM+e]) : 0;
                    r = (p <= n) ? m + l : m - l;
                end
                cnt++;
                pt = '{p[3:0], e[2:0], clip32(r), STATUS_OK, cnt == total};
                expected_points.push_back(pt);
            end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        point_t want;
        if (!rst_n)
        begin
            dim_reg = 3'd1;
            spread_reg = 31'd65536;
            expected_points.delete();
            errors = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_DIM)
                    dim_reg = cfg.data[2:0];
                else
                    spread_reg = cfg.data;
            end
            if (in_ch.valid && in_ch.ready)
            begin
                case (in_ch.action)
                    ACT_LOAD_MEAN:
                        if (in_ch.row_index < MAX_DIM)
                            mean_mem[in_ch.row_index] = in_ch.value;
                    ACT_LOAD_COV:
                        if (in_ch.row_index < MAX_DIM && in_ch.col_index < MAX_DIM)
                            fac_mem[in_ch.row_index*MAX_DIM+in_ch.col_index] = in_ch.value;
                    ACT_GENERATE:
                        predict_points();
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (expected_points.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result point %0d element %0d value %0d",
                             $time, out_ch.point_index, out_ch.element_index,
                             out_ch.point_value);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (out_ch.point_index !== want.point_index ||
                        out_ch.element_index !== want.element_index ||
                        out_ch.point_value !== want.point_value ||
                        out_ch.status !== want.status || out_ch.last !== want.last)
                    begin
                        errors++;
                        $display("%0t: mismatch expected p=%0d e=%0d v=%0d st=%0d last=%0d",
                                 $time, want.point_index, want.element_index,
                                 want.point_value, want.status, want.last);
                        $display("%0t:          actual   p=%0d e=%0d v=%0d st=%0d last=%0d",
                                 $time, out_ch.point_index, out_ch.element_index,
                                 out_ch.point_value, out_ch.status, out_ch.last);
                    end
                end
            end
        end
        pending = expected_points.size();
    end
endmodule

### verif/sigma_point_generator_test.sv
// testbench top for the sigma point generator: clock, reset, stimulus and verdict
// depends on spg_pkg, spg_if, spg_checker and the block itself
module sigma_point_generator_test;
    import spg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    int   errors, pending, results_seen;
    int   src_idle, sink_stall;
    int   items_sent, generates_sent, cfg_writes;

    spg_in_if  in_ch();
    spg_out_if out_ch();
    spg_cfg_if cfg();

    sigma_point_generator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    spg_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg          (cfg),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout with %0d results outstanding", pending);
        $display("RESULT: ERROR");
        $finish;
    end

    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= sink_stall);

    task automatic put_item(input action_t act, input logic [2:0] row, input logic [2:0] col,
                            input logic signed [31:0] val);
        while ($urandom_range(99) < src_idle)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.row_index <= row;
        in_ch.col_index <= col;
        in_ch.value <= val;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        items_sent++;
        if (act == ACT_GENERATE)
            generates_sent++;
    endtask

    // registers change only once every pending point has drained
    task automatic write_reg(input reg_index_t idx, input logic [30:0] data);
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic signed [31:0] any_value();
        case ($urandom_range(3))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // a diagonally dominant matrix stays positive definite under a nonzero spread
    task automatic load_problem(input int n, input bit broken);
        logic signed [31:0] diag;
        for (int e = 0; e < n; e++)
            put_item(ACT_LOAD_MEAN, e[2:0], 3'($urandom), ($urandom_range(4) == 0) ?
                     any_value() : $signed($urandom_range(0, 1 << 24)) - (1 << 23));
        for (int i = 0; i < n; i++)
        begin
            diag = $urandom_range(1 << 16, 1 << 22);
            for (int j = 0; j <= i; j++)
            begin
                if (broken)
                    put_item(ACT_LOAD_COV, i[2:0], j[2:0], any_value());
                else if (i == j)
                    put_item(ACT_LOAD_COV, i[2:0], j[2:0], diag);
                else
                    put_item(ACT_LOAD_COV, i[2:0], j[2:0],
                             $signed($urandom_range(0, 1 << 14)) - (1 << 13));
                // stray transfers that the block drops
                if ($urandom_range(9) == 0)
                    put_item(ACT_UNUSED, 3'($urandom), 3'($urandom), $urandom);
                if ($urandom_range(9) == 0)
                    put_item(action_t'($urandom_range(1)), 3'($urandom_range(5, 7)),
                             3'($urandom), $urandom);
            end
        end
    endtask

    initial
    begin
        logic [2:0] dim_sel;
        logic [30:0] spread_sel;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_LOAD_MEAN;
        in_ch.row_index = '0;
        in_ch.col_index = '0;
        in_ch.value = '0;
        out_ch.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_DIM;
        cfg.data = '0;
        src_idle = 0;
        sink_stall = 0;
        items_sent = 0;
        generates_sent = 0;
        cfg_writes = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: fill every store entry, then extremes and corner cases
        write_reg(REG_DIM, 31'd5);
        put_item(ACT_LOAD_MEAN, 3'd0, 3'd0, 32'sh7FFF_FFFF);
        put_item(ACT_LOAD_MEAN, 3'd1, 3'd0, 32'sh8000_0000);
        put_item(ACT_LOAD_MEAN, 3'd2, 3'd0, 32'sd0);
        put_item(ACT_LOAD_MEAN, 3'd3, 3'd0, 32'sh0001_0000);
        put_item(ACT_LOAD_MEAN, 3'd4, 3'd0, -32'sh0001_0000);
        for (int i = 0; i < MAX_DIM; i++)
            for (int j = 0; j < MAX_DIM; j++)
                put_item(ACT_LOAD_COV, i[2:0], j[2:0],
                         (i == j) ? 32'sh0004_0000 : ((j > i) ? 32'sh7FFF_FFFF : 32'sd0));
        put_item(ACT_GENERATE, 3'd0, 3'd0, 32'sd0);
        put_item(ACT_GENERATE, 3'd7, 3'd7, -32'sd1);
        put_item(ACT_UNUSED, 3'd7, 3'd7, 32'sh8000_0000);
        put_item(ACT_LOAD_MEAN, 3'd7, 3'd0, 32'sh7FFF_FFFF);
        put_item(ACT_LOAD_COV, 3'd2, 3'd7, -32'sd1);
        // zero pivot on the second row
        put_item(ACT_LOAD_COV, 3'd1, 3'd1, 32'sd0);
        put_item(ACT_GENERATE, 3'd0, 3'd0, 32'sd0);
        write_reg(REG_SPREAD, 31'h7FFF_FFFF);
        write_reg(REG_DIM, 31'd0);
        put_item(ACT_GENERATE, 3'd0, 3'd0, 32'sd0);
        write_reg(REG_DIM, 31'd7);
        write_reg(REG_SPREAD, 31'd0);
        put_item(ACT_GENERATE, 3'd0, 3'd0, 32'sd0);
        write_reg(REG_DIM, 31'd6);
        write_reg(REG_SPREAD, 31'd65536);
        put_item(ACT_GENERATE, 3'd0, 3'd0, 32'sd0);

        // random: four phases of varied idling; mostly sound problems with some noise
        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 34 : 55) : 0;
            sink_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 34 : 55) : 0;
            while (items_sent < 25 + (ph + 1) * 78)
            begin
                if ($urandom_range(2) == 0)
                begin
                    dim_sel = $urandom_range(7);
                    write_reg(REG_DIM, 31'(dim_sel));
                end
                if ($urandom_range(2) == 0)
                begin
                    case ($urandom_range(9))
                        0: spread_sel = 31'd0;
                        1: spread_sel = 31'h7FFF_FFFF;
                        2: spread_sel = $urandom;
                        default: spread_sel = $urandom_range(1 << 14, 1 << 19);
                    endcase
                    write_reg(REG_SPREAD, spread_sel);
                end
                load_problem($urandom_range(1, MAX_DIM), $urandom_range(4) == 0);
                put_item(ACT_GENERATE, 3'($urandom), 3'($urandom), $urandom);
                if ($urandom_range(5) == 0)
                    put_item(ACT_GENERATE, 3'($urandom), 3'($urandom), $urandom);
            end
        end
        in_ch.valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        $display("covered %0d transfers in, %0d generates, %0d register writes",
                 items_sent, generates_sent, cfg_writes);
        $display("checked %0d sigma point results over four idling phases", results_seen);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

### filelist.f
rtl/core/spg_pkg.sv
rtl/core/spg_if.sv
rtl/core/spg_sqrt.sv
rtl/core/spg_div.sv
rtl/core/sigma_point_generator.sv
verif/spg_checker.sv
verif/sigma_point_generator_test.sv
